// ===== sv/ezq_pkg.sv =====
// ----------------------------------------------------------------------------
// ezq_pkg: shared types and constants
// CORDIC angle table, gain and fixed-point widths for the Euler converter.
// ----------------------------------------------------------------------------
package ezq_pkg;

	localparam int ATAN_ENTRIES = 24;
	localparam int TRIG_STAGES_DEF = 16;
	localparam int VEC_W = 34;   // Q2.30 plus guard bits
	localparam int ANG_W = 26;   // residual angle, 2^-16 degree
	localparam int TRIG_W = 26;  // Q24 trig value
	localparam int OUT_W = 18;

	localparam logic signed [VEC_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [ANG_W-1:0] DEG90 = 26'sd5898240;
	localparam logic signed [ANG_W-1:0] DEG180 = 26'sd11796480;
	localparam logic signed [ANG_W-1:0] DEG360 = 26'sd23592960;

	typedef struct packed {
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic signed [ANG_W-1:0] h;
		logic flip;
	} cordic_t;

	typedef struct packed {
		cordic_t ax;
		cordic_t ay;
		cordic_t az;
	} cell_data_t;

	function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] i);
		logic signed [ANG_W-1:0] r;
		unique case (i)
			5'd0: r = 26'sd2949120;
			5'd1: r = 26'sd1740967;
			5'd2: r = 26'sd919879;
			5'd3: r = 26'sd466945;
			5'd4: r = 26'sd234379;
			5'd5: r = 26'sd117304;
			5'd6: r = 26'sd58666;
			5'd7: r = 26'sd29335;
			5'd8: r = 26'sd14668;
			5'd9: r = 26'sd7334;
			5'd10: r = 26'sd3667;
			5'd11: r = 26'sd1833;
			5'd12: r = 26'sd917;
			5'd13: r = 26'sd458;
			5'd14: r = 26'sd229;
			5'd15: r = 26'sd115;
			5'd16: r = 26'sd57;
			5'd17: r = 26'sd29;
			5'd18: r = 26'sd14;
			5'd19: r = 26'sd7;
			5'd20: r = 26'sd4;
			5'd21: r = 26'sd2;
			5'd22: r = 26'sd1;
			default: r = 26'sd0;
		endcase
		return r;
	endfunction

endpackage

// ===== sv/ezq_cell.sv =====
// ----------------------------------------------------------------------------
// ezq_cell: one CORDIC micro-rotation for all three axes
// Rotates each vector toward zero residual angle and registers the result.
// ----------------------------------------------------------------------------
module ezq_cell #(
	parameter int STAGE = 0
) (
	input  logic                clk,
	input  logic                en,
	input  ezq_pkg::cell_data_t din,
	output ezq_pkg::cell_data_t dout_s1
);

	localparam logic [4:0] IDX = 5'(STAGE);

	function automatic ezq_pkg::cordic_t rot(input ezq_pkg::cordic_t a);
		ezq_pkg::cordic_t r;
		logic signed [ezq_pkg::VEC_W-1:0] dx;
		logic signed [ezq_pkg::VEC_W-1:0] dy;
		dx = a.vy >>> STAGE;
		dy = a.vx >>> STAGE;
		r = a;
		if (!a.h[ezq_pkg::ANG_W-1]) begin
			r.vx = a.vx - dx;
			r.vy = a.vy + dy;
			r.h = a.h - ezq_pkg::atan_lut(IDX);
		end else begin
			r.vx = a.vx + dx;
			r.vy = a.vy - dy;
			r.h = a.h + ezq_pkg::atan_lut(IDX);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			dout_s1.ax <= rot(din.ax);
			dout_s1.ay <= rot(din.ay);
			dout_s1.az <= rot(din.az);
		end
	end

endmodule

// ===== sv/ezq_product.sv =====
// ----------------------------------------------------------------------------
// ezq_product: quaternion product qz*qx*qy
// Four-stage pipeline: trig rounding, first product, second product, output.
// ----------------------------------------------------------------------------
module ezq_product (
	input  logic                       clk,
	input  logic [3:0]                 en,
	input  ezq_pkg::cell_data_t        din,
	output logic signed [ezq_pkg::OUT_W-1:0] w_s4,
	output logic signed [ezq_pkg::OUT_W-1:0] x_s4,
	output logic signed [ezq_pkg::OUT_W-1:0] y_s4,
	output logic signed [ezq_pkg::OUT_W-1:0] z_s4
);

	localparam int TW = ezq_pkg::TRIG_W;

	function automatic logic signed [TW-1:0] to_q24(input logic signed [ezq_pkg::VEC_W-1:0] v,
			input logic flip);
		logic signed [ezq_pkg::VEC_W-1:0] n;
		logic signed [ezq_pkg::VEC_W-1:0] t;
		n = flip ? -v : v;
		t = (n + 34'sd32) >>> 6;
		return t[TW-1:0];
	endfunction

	function automatic logic signed [TW-1:0] q24(input logic signed [51:0] p);
		logic signed [51:0] t;
		t = (p + 52'sd8388608) >>> 24;
		return t[TW-1:0];
	endfunction

	function automatic logic signed [ezq_pkg::OUT_W-1:0] sat(input logic signed [52:0] p);
		logic signed [52:0] t;
		t = (p + 53'sd2147483648) >>> 32;
		if (t > 53'sd65536) t = 53'sd65536;
		else if (t < -53'sd65536) t = -53'sd65536;
		return t[ezq_pkg::OUT_W-1:0];
	endfunction

	logic signed [TW-1:0] cx_s1, sx_s1, cy_s1, sy_s1, cz_s1, sz_s1;
	logic signed [TW-1:0] pw_s2, px_s2, py_s2, pz_s2, cy_s2, sy_s2;
	logic signed [51:0] m0_s3, m1_s3, m2_s3, m3_s3, m4_s3, m5_s3, m6_s3, m7_s3;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			cx_s1 <= to_q24(din.ax.vx, din.ax.flip);
			sx_s1 <= to_q24(din.ax.vy, din.ax.flip);
			cy_s1 <= to_q24(din.ay.vx, din.ay.flip);
			sy_s1 <= to_q24(din.ay.vy, din.ay.flip);
			cz_s1 <= to_q24(din.az.vx, din.az.flip);
			sz_s1 <= to_q24(din.az.vy, din.az.flip);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pw_s2 <= q24(52'(cz_s1 * cx_s1));
			px_s2 <= q24(52'(cz_s1 * sx_s1));
			py_s2 <= q24(52'(sz_s1 * sx_s1));
			pz_s2 <= q24(52'(sz_s1 * cx_s1));
			cy_s2 <= cy_s1;
			sy_s2 <= sy_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			m0_s3 <= 52'(pw_s2 * cy_s2);
			m1_s3 <= 52'(py_s2 * sy_s2);
			m2_s3 <= 52'(px_s2 * cy_s2);
			m3_s3 <= 52'(pz_s2 * sy_s2);
			m4_s3 <= 52'(pw_s2 * sy_s2);
			m5_s3 <= 52'(py_s2 * cy_s2);
			m6_s3 <= 52'(pz_s2 * cy_s2);
			m7_s3 <= 52'(px_s2 * sy_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			w_s4 <= sat(53'(m0_s3) - 53'(m1_s3));
			x_s4 <= sat(53'(m2_s3) - 53'(m3_s3));
			y_s4 <= sat(53'(m4_s3) + 53'(m5_s3));
			z_s4 <= sat(53'(m6_s3) + 53'(m7_s3));
		end
	end

endmodule

// ===== sv/euler_zxy_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// euler_zxy_to_quaternion: Euler angles (Z, X, Y) to rotation quaternion
// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_ready  angle_x, angle_y, angle_z (s16)
// output    out        out_valid/out_ready quat_w/x/y/z (s18, Q2.16)
// One request per cycle while out_ready keeps the output moving; the data path
// is the input register, the row of CORDIC cells (one per stage) and the
// four-stage product pipeline.
// A stage moves when the next one moves or is empty; a stalled output holds
// the full stages behind it, and bubbles are squeezed out.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module euler_zxy_to_quaternion #(
	parameter int TRIG_STAGES = ezq_pkg::TRIG_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [15:0] angle_x,
	input  logic signed [15:0] angle_y,
	input  logic signed [15:0] angle_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [ezq_pkg::OUT_W-1:0] quat_w,
	output logic signed [ezq_pkg::OUT_W-1:0] quat_x,
	output logic signed [ezq_pkg::OUT_W-1:0] quat_y,
	output logic signed [ezq_pkg::OUT_W-1:0] quat_z
);

	localparam int NC = (TRIG_STAGES > ezq_pkg::ATAN_ENTRIES) ? ezq_pkg::ATAN_ENTRIES
		: TRIG_STAGES;
	localparam int DEPTH = NC + 5;

	function automatic ezq_pkg::cordic_t prep(input logic signed [15:0] a);
		ezq_pkg::cordic_t r;
		logic signed [ezq_pkg::ANG_W-1:0] h;
		h = ezq_pkg::ANG_W'(a) <<< 9;
		if (h > ezq_pkg::DEG180) h = h - ezq_pkg::DEG360;
		else if (h < -ezq_pkg::DEG180) h = h + ezq_pkg::DEG360;
		r.flip = 1'b0;
		if (h > ezq_pkg::DEG90) begin
			h = h - ezq_pkg::DEG180;
			r.flip = 1'b1;
		end else if (h < -ezq_pkg::DEG90) begin
			h = h + ezq_pkg::DEG180;
			r.flip = 1'b1;
		end
		r.h = h;
		r.vx = ezq_pkg::CORDIC_GAIN;
		r.vy = '0;
		return r;
	endfunction

	logic [DEPTH-1:0] vld_q;
	logic [DEPTH-1:0] adv;
	ezq_pkg::cell_data_t pre_s1;
	ezq_pkg::cell_data_t chain [NC+1];

	// stage i advances when it can hand on or is empty
	always_comb begin
		adv[DEPTH-1] = out_ready || !vld_q[DEPTH-1];
		for (int i = DEPTH-2; i >= 0; i--) begin
			adv[i] = adv[i+1] || !vld_q[i];
		end
	end

	assign in_ready = adv[0];
	assign out_valid = vld_q[DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) vld_q[0] <= in_valid;
			for (int i = 1; i < DEPTH; i++) begin
				if (adv[i]) vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			pre_s1.ax <= prep(angle_x);
			pre_s1.ay <= prep(angle_y);
			pre_s1.az <= prep(angle_z);
		end
	end

	assign chain[0] = pre_s1;

	for (genvar g = 0; g < NC; g++) begin : g_cell
		ezq_cell #(.STAGE(g)) u_cell (
			.clk    (clk),
			.en     (adv[g+1]),
			.din    (chain[g]),
			.dout_s1(chain[g+1])
		);
	end

	ezq_product u_prod (
		.clk (clk),
		.en  (adv[NC+4:NC+1]),
		.din (chain[NC]),
		.w_s4(quat_w),
		.x_s4(quat_x),
		.y_s4(quat_y),
		.z_s4(quat_z)
	);

endmodule

// ===== tb/euler_zxy_to_quaternion_test.sv =====
// ----------------------------------------------------------------------------
// euler_zxy_to_quaternion_test: self-checking bench for the Euler converter
// Drives angle triples over valid/ready with random idling on both sides,
// predicts each quaternion with a local CORDIC and product model, and
// compares every result field by field in order of arrival.
// ----------------------------------------------------------------------------
module euler_zxy_to_quaternion_test;

	localparam int STAGES = ezq_pkg::TRIG_STAGES_DEF;
	localparam int LATENCY = STAGES + 5;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int N_RANDOM = 1800;
	localparam int N_DIRECTED = 18;

	typedef struct packed {
		logic signed [17:0] w;
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic signed [17:0] z;
	} quat_t;

	typedef struct {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] az;
		bit                 known;
		quat_t              q;
	} angle_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] angle_x;
	logic signed [15:0] angle_y;
	logic signed [15:0] angle_z;
	logic out_valid;
	logic out_ready;
	logic signed [17:0] quat_w;
	logic signed [17:0] quat_x;
	logic signed [17:0] quat_y;
	logic signed [17:0] quat_z;

	quat_t pending_quats[$];
	int    mismatches;
	int    results_seen;
	int    idle_cycles;
	int    send_idle_pct;
	int    recv_idle_pct;
	bit    timed_out;

	angle_row_t directed[N_DIRECTED];

	euler_zxy_to_quaternion dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z),
		.out_valid(out_valid), .out_ready(out_ready),
		.quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint atan_step(int i);
		longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2,
			1, 0};
		return tbl[i];
	endfunction

	// cosine and sine of half the angle, Q24
	task automatic half_angle_trig(input logic signed [15:0] a, output longint c,
		output longint s);
		longint h;
		longint vx;
		longint vy;
		longint dx;
		longint dy;
		bit     flip;
		int     n;
		h = longint'(a) * 512;
		vx = 652032874;
		vy = 0;
		flip = 0;
		n = (STAGES > 24) ? 24 : STAGES;
		if (h > 180 * 65536) h -= 360 * 65536;
		else if (h < -180 * 65536) h += 360 * 65536;
		if (h > 90 * 65536) begin
			h -= 180 * 65536;
			flip = 1;
		end else if (h < -90 * 65536) begin
			h += 180 * 65536;
			flip = 1;
		end
		for (int i = 0; i < n; i++) begin
			dx = floor_shr(vy, i);
			dy = floor_shr(vx, i);
			if (h >= 0) begin
				vx -= dx;
				vy += dy;
				h -= atan_step(i);
			end else begin
				vx += dx;
				vy -= dy;
				h += atan_step(i);
			end
		end
		if (flip) begin
			vx = -vx;
			vy = -vy;
		end
		c = floor_shr(vx + 32, 6);
		s = floor_shr(vy + 32, 6);
	endtask

	function automatic logic signed [17:0] round_q16(longint v);
		longint r;
		r = floor_shr(v + (longint'(1) << 31), 32);
		if (r > 65536) r = 65536;
		if (r < -65536) r = -65536;
		return r[17:0];
	endfunction

	function automatic longint round_q24(longint v);
		return floor_shr(v + (longint'(1) << 23), 24);
	endfunction

	task automatic rotation_quat(input logic signed [15:0] ax, ay, az, output quat_t q);
		longint cx, sx, cy, sy, cz, sz;
		longint pw, px, py, pz;
		half_angle_trig(ax, cx, sx);
		half_angle_trig(ay, cy, sy);
		half_angle_trig(az, cz, sz);
		pw = round_q24(cz * cx);
		px = round_q24(cz * sx);
		py = round_q24(sz * sx);
		pz = round_q24(sz * cx);
		q.w = round_q16(pw * cy - py * sy);
		q.x = round_q16(px * cy - pz * sy);
		q.y = round_q16(pw * sy + py * cy);
		q.z = round_q16(pz * cy + px * sy);
	endtask

	task automatic report_mismatch(input string what, input logic signed [17:0] got,
		input logic signed [17:0] want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		mismatches++;
	endtask

	// send one request, holding valid until accepted; drop valid only while idling
	task automatic send_angles(input logic signed [15:0] ax, ay, az, input bit known,
		input quat_t given);
		quat_t q;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		rotation_quat(ax, ay, az, q);
		if (known) q = given;
		in_valid <= 1'b1;
		angle_x <= ax;
		angle_y <= ay;
		angle_z <= az;
		pending_quats.push_back(q);
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// receiver: random stall, check on each accepted result
	always @(posedge clk) begin
		quat_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_quats.size() == 0) begin
					report_mismatch("result with nothing expected", quat_w, '0);
				end else begin
					want = pending_quats.pop_front();
					results_seen++;
					if (quat_w !== want.w) report_mismatch("quat_w", quat_w, want.w);
					if (quat_x !== want.x) report_mismatch("quat_x", quat_x, want.x);
					if (quat_y !== want.y) report_mismatch("quat_y", quat_y, want.y);
					if (quat_z !== want.z) report_mismatch("quat_z", quat_z, want.z);
				end
			end
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog: count cycles with no request or result moving
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) ||
			(!in_valid && pending_quats.size() == 0)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog expired");
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	task automatic run_random(input int count, input int s_pct, input int r_pct);
		logic signed [15:0] a[3];
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int n = 0; n < count; n++) begin
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(3))
					0: a[k] = 16'($urandom);
					1: a[k] = 16'($urandom_range(46080) - 23040); // within one turn
					2: a[k] = 16'(($urandom_range(8) * 2880) - 11520 + $urandom_range(2) - 1);
					default: a[k] = $urandom_range(2) ? 16'(16'sh7fff - $urandom_range(3))
						: 16'(16'sh8000 + $urandom_range(3));
				endcase
			end
			send_angles(a[0], a[1], a[2], 1'b0, '0);
		end
	endtask

	initial begin
		int    sent;
		// every row is checked against the predictor
		directed[0] = '{16'sd0, 16'sd0, 16'sd0, 1'b0, '0};
		directed[1] = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '0};
		directed[2] = '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '0};
		directed[3] = '{16'sd11520, 16'sd0, 16'sd0, 1'b0, '0};
		directed[4] = '{16'sd0, 16'sd11520, 16'sd0, 1'b0, '0};
		directed[5] = '{16'sd0, 16'sd0, 16'sd11520, 1'b0, '0};
		directed[6] = '{16'sd11521, -16'sd11521, 16'sd11519, 1'b0, '0};
		directed[7] = '{16'sd23040, 16'sd23040, -16'sd23040, 1'b0, '0};
		directed[8] = '{16'sd23041, -16'sd23041, 16'sd23039, 1'b0, '0};
		directed[9] = '{-16'sd11520, -16'sd11520, -16'sd11520, 1'b0, '0};
		directed[10] = '{16'sd5760, 16'sd5760, 16'sd5760, 1'b0, '0};
		directed[11] = '{16'sd1, -16'sd1, 16'sd1, 1'b0, '0};
		directed[12] = '{16'sh5555, 16'shaaaa, 16'sh5555, 1'b0, '0};
		directed[13] = '{16'shaaaa, 16'sh5555, 16'shaaaa, 1'b0, '0};
		directed[14] = '{16'sd17280, 16'sd2880, -16'sd17280, 1'b0, '0};
		directed[15] = '{-16'sd32767, 16'sd32767, 16'sd0, 1'b0, '0};
		directed[16] = '{16'sh00ff, 16'shff00, 16'sh0f0f, 1'b0, '0};
		directed[17] = '{16'sd0, 16'sh8000, 16'sh7fff, 1'b0, '0};

		mismatches = 0;
		results_seen = 0;
		idle_cycles = 0;
		send_idle_pct = 19;
		recv_idle_pct = 45;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		angle_x = '0;
		angle_y = '0;
		angle_z = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_angles(directed[i].ax, directed[i].ay, directed[i].az,
				directed[i].known, directed[i].q);
		run_random(N_RANDOM / 3, 19, 45);
		// hold off until the pipeline has drained
		in_valid <= 1'b0;
		while (pending_quats.size() != 0) @(posedge clk);
		run_random(N_RANDOM / 3, 45, 19);
		run_random(N_RANDOM / 3, 0, 0);
		in_valid <= 1'b0;
		sent = N_DIRECTED + N_RANDOM;

		while (pending_quats.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		$display("covered %0d angle triples, %0d quaternions checked", sent, results_seen);
		$display("directed extremes, fold-over cases and three idling mixes");
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ezq_pkg.sv
sv/ezq_cell.sv
sv/ezq_product.sv
sv/euler_zxy_to_quaternion.sv
tb/euler_zxy_to_quaternion_test.sv
